/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the rate limiter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Implication or plain property, checked on every rising edge outside reset.
`define HKRLF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define HKRLF_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define HKRLF_ASSERT(lbl, clk, rst_n, prop, msg)
`define HKRLF_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* rtl/hkrlf_pkg.sv */
// ----------------------------------------------------------------------------
// hkrlf_pkg
// Types and constants shared by the hashed key rate limit filter.
// ----------------------------------------------------------------------------
package hkrlf_pkg;

	localparam int unsigned KEY_W          = 32;
	localparam int unsigned TIME_W         = 32;
	localparam int unsigned INTERVAL_W     = 16;

	// Fibonacci hash multiplier and the number of product bits kept.
	localparam logic [KEY_W-1:0] HASH_MULT = 32'd2654435761;
	localparam int unsigned HASH_TOP_W     = 11;

	localparam int unsigned TABLE_ENTRIES_DEF = 2048;
	localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RST = 16'd1;

	// Depth of the queue between the front and back parts.
	localparam int unsigned QUEUE_DEPTH    = 2;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [TIME_W-1:0] now_sec;
	} item_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECIDE
	} back_state_t;

endpackage

/* rtl/hkrlf_front.sv */
// ----------------------------------------------------------------------------
// hkrlf_front
// Accepts items and computes their table slot in a three stage pipeline.
// ----------------------------------------------------------------------------
module hkrlf_front #(
	parameter int unsigned TABLE_ENTRIES = hkrlf_pkg::TABLE_ENTRIES_DEF,
	parameter int unsigned IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept_en,
	input  logic                in_valid,
	output logic                in_ready,
	input  hkrlf_pkg::item_t    in_item,
	output logic                push,
	input  logic                push_ready,
	output hkrlf_pkg::item_t    push_item,
	output logic [IDX_W-1:0]    push_slot
);

	localparam int unsigned TOP_W    = hkrlf_pkg::HASH_TOP_W;
	localparam int unsigned RECIP_SH = 2 * TOP_W;
	localparam int unsigned RECIP_W  = RECIP_SH + 1;
	localparam int unsigned QP_W     = TOP_W + RECIP_W;
	localparam int unsigned REM_W    = 2 * TOP_W + 1;
	// Rounded-up reciprocal; exact quotient for every value below 2^TOP_W.
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SH) + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES));
	localparam logic [TOP_W:0] ENTRIES_C = (TOP_W + 1)'(TABLE_ENTRIES);

	logic                   adv;
	logic                   v_s1, v_s2, v_s3;
	hkrlf_pkg::item_t       item_s1, item_s2, item_s3;
	logic [TOP_W-1:0]       top_s1, top_s2;
	logic [TOP_W-1:0]       quo_s2;
	logic [IDX_W-1:0]       slot_s3;
	logic [hkrlf_pkg::KEY_W-1:0] prod;
	logic [QP_W-1:0]        qprod;
	logic [REM_W-1:0]       rem_full;

	// The whole pipeline holds when the last stage cannot move into the queue.
	assign adv      = !v_s3 || push_ready;
	assign in_ready = adv && accept_en;

	assign prod     = in_item.key * hkrlf_pkg::HASH_MULT;
	assign qprod    = QP_W'(top_s1) * QP_W'(RECIP);
	assign rem_full = REM_W'(top_s2) - REM_W'(quo_s2) * REM_W'(ENTRIES_C);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid && in_ready;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= in_item;
			top_s1  <= prod[hkrlf_pkg::KEY_W-1 -: TOP_W];
			item_s2 <= item_s1;
			top_s2  <= top_s1;
			quo_s2  <= qprod[RECIP_SH +: TOP_W];
			item_s3 <= item_s2;
			slot_s3 <= rem_full[IDX_W-1:0];
		end
	end

	assign push      = v_s3 && push_ready;
	assign push_item = item_s3;
	assign push_slot = slot_s3;

endmodule

/* rtl/hkrlf_fifo.sv */
// ----------------------------------------------------------------------------
// hkrlf_fifo
// Short register queue that decouples the front and back parts.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hkrlf_fifo #(
	parameter int unsigned DATA_W = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [DATA_W-1:0] wr_data,
	output logic              not_full,
	output logic              not_empty,
	input  logic              rd_en,
	output logic [DATA_W-1:0] rd_data
);

	localparam int unsigned DEPTH = hkrlf_pkg::QUEUE_DEPTH;
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_C = CNT_W'(DEPTH);
	localparam logic [PTR_W-1:0] LAST_C = PTR_W'(DEPTH - 1);

	logic [DATA_W-1:0] slots_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_wr, do_rd;

	assign not_full  = count_q != FULL_C;
	assign not_empty = count_q != '0;
	assign do_wr     = wr_en && not_full;
	assign do_rd     = rd_en && not_empty;
	assign rd_data   = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_C) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_C) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

	`HKRLF_NEVER(a_no_push_when_full, clk, arst_n, wr_en && !not_full, "push into full queue")
	`HKRLF_NEVER(a_count_in_range, clk, arst_n, count_q > FULL_C, "queue count out of range")

endmodule

/* rtl/hkrlf_back.sv */
// ----------------------------------------------------------------------------
// hkrlf_back
// Table memory, clearing pass, read-compare-write decision and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hkrlf_back #(
	parameter int unsigned TABLE_ENTRIES = hkrlf_pkg::TABLE_ENTRIES_DEF,
	parameter int unsigned IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_valid,
	output logic                                 q_ready,
	input  hkrlf_pkg::item_t                     q_item,
	input  logic [IDX_W-1:0]                     q_slot,
	input  logic [hkrlf_pkg::INTERVAL_W-1:0]     min_interval,
	output logic                                 clearing,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 should_log
);

	localparam int unsigned KW    = hkrlf_pkg::KEY_W;
	localparam int unsigned TW    = hkrlf_pkg::TIME_W;
	localparam int unsigned ENT_W = KW + TW;
	localparam int unsigned DIF_W = TW + 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	hkrlf_pkg::back_state_t state_q, state_d;

	logic [ENT_W-1:0]  mem [TABLE_ENTRIES];
	logic [ENT_W-1:0]  rd_q;
	hkrlf_pkg::item_t  item_q;
	logic [IDX_W-1:0]  slot_q;
	logic [IDX_W-1:0]  clr_q;
	logic              out_valid_q;
	logic              log_q;

	logic              rd_en;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_addr;
	logic [ENT_W-1:0]  mem_wdata;
	logic              out_free;
	logic              decide_fire;
	logic              key_hit;
	logic signed [DIF_W-1:0] diff;
	logic              too_soon;
	logic              log_d;

	assign out_free    = !out_valid_q || out_ready;
	assign decide_fire = (state_q == hkrlf_pkg::ST_DECIDE) && out_free;

	// Elapsed time is an exact signed difference of two unsigned seconds values.
	assign key_hit  = rd_q[ENT_W-1 -: KW] == item_q.key;
	assign diff     = $signed({1'b0, item_q.now_sec}) - $signed({1'b0, rd_q[TW-1:0]});
	assign too_soon = key_hit && (diff < $signed(DIF_W'(min_interval)));
	assign log_d    = !too_soon;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hkrlf_pkg::ST_CLEAR: begin
				if (clr_q == LAST_IDX) begin
					state_d = hkrlf_pkg::ST_IDLE;
				end
			end
			hkrlf_pkg::ST_IDLE: begin
				if (q_valid) begin
					state_d = hkrlf_pkg::ST_DECIDE;
				end
			end
			hkrlf_pkg::ST_DECIDE: begin
				if (out_free) begin
					state_d = hkrlf_pkg::ST_IDLE;
				end
			end
			default: state_d = hkrlf_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		q_ready   = 1'b0;
		rd_en     = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = slot_q;
		mem_wdata = {item_q.key, item_q.now_sec};
		clearing  = 1'b0;
		unique case (state_q)
			hkrlf_pkg::ST_CLEAR: begin
				clearing  = 1'b1;
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = '0;
			end
			hkrlf_pkg::ST_IDLE: begin
				q_ready = 1'b1;
				rd_en   = q_valid;
			end
			hkrlf_pkg::ST_DECIDE: begin
				mem_we = out_free && log_d;
			end
			default: begin
				clearing = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hkrlf_pkg::ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == hkrlf_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (decide_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			item_q <= q_item;
			slot_q <= q_slot;
		end
		if (decide_fire) begin
			log_q <= log_d;
		end
	end

	// Reads and writes never fall in the same cycle, so no bypass is needed.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_q <= mem[q_slot];
		end
	end

	assign out_valid  = out_valid_q;
	assign should_log = log_q;

	`HKRLF_ASSERT(a_we_phase, clk, arst_n, mem_we |-> (state_q == hkrlf_pkg::ST_CLEAR || decide_fire), "table write outside clear or decide")
	`HKRLF_ASSERT(a_pop_idle, clk, arst_n, rd_en |-> (state_q == hkrlf_pkg::ST_IDLE && !clearing), "queue pop outside idle")
	`HKRLF_ASSERT(a_result_src, clk, arst_n, $rose(out_valid_q) |-> $past(state_q) == hkrlf_pkg::ST_DECIDE, "result without decision")
	`HKRLF_NEVER(a_suppress_no_write, clk, arst_n, decide_fire && !log_d && mem_we, "suppressed event wrote table")

endmodule

/* rtl/hashed_key_rate_limit_filter.sv */
// ----------------------------------------------------------------------------
// hashed_key_rate_limit_filter
// Per-key event rate limiter on a direct-mapped hashed table.
// ----------------------------------------------------------------------------
// Each transfer on the input channel carries a key and a time in seconds and
// produces exactly one transfer on the output channel telling whether the
// event is to be logged (should_log = 1) or suppressed. The key is hashed with
// a Fibonacci multiply, its top 11 bits are reduced modulo TABLE_ENTRIES, and
// that slot holds the last key and last logged time. A different key replaces
// the slot and logs; the same key logs and refreshes the time only when at
// least min_interval_sec seconds have passed, while a time that went backwards
// is suppressed. After reset the table is swept to zero, one entry per cycle;
// in_ready stays low during that sweep. In steady state the back part
// handles one item at a time: in the idle state it reads the single-port
// table memory, and in the decide state it compares and writes it back,
// waiting there while the result register is still full. The front part
// computes the slot in three pipelined stages and a two-entry queue sits
// between the two. The user must write the interval register through cfg_wen
// and cfg_wdata only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module hashed_key_rate_limit_filter #(
	parameter int unsigned TABLE_ENTRIES = hkrlf_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [hkrlf_pkg::KEY_W-1:0]          key,
	input  logic [hkrlf_pkg::TIME_W-1:0]         now_sec,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 should_log,
	input  logic                                 cfg_wen,
	input  logic [hkrlf_pkg::INTERVAL_W-1:0]     cfg_wdata
);

	// Slot index width; a one-entry table still gets a single index bit.
	localparam int unsigned IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned ITEM_W = $bits(hkrlf_pkg::item_t);
	localparam int unsigned Q_W    = ITEM_W + IDX_W;

	// Minimum interval register, reset to one second.
	logic [hkrlf_pkg::INTERVAL_W-1:0] min_interval_q;

	hkrlf_pkg::item_t    in_item;
	hkrlf_pkg::item_t    push_item;
	logic [IDX_W-1:0]    push_slot;
	logic                push;
	logic                q_not_full;
	logic                q_not_empty;
	logic                q_pop;
	logic [Q_W-1:0]      q_rd_data;
	hkrlf_pkg::item_t    q_item;
	logic [IDX_W-1:0]    q_slot;
	logic                clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_interval_q <= hkrlf_pkg::MIN_INTERVAL_RST;
		end else if (cfg_wen) begin
			min_interval_q <= cfg_wdata;
		end
	end

	assign in_item.key     = key;
	assign in_item.now_sec = now_sec;

	// Front part: hashing and slot reduction. It takes no transfer while the
	// table is being cleared.
	hkrlf_front #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.IDX_W         (IDX_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept_en  (!clearing),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.push       (push),
		.push_ready (q_not_full),
		.push_item  (push_item),
		.push_slot  (push_slot)
	);

	// Queue carrying the item together with its precomputed slot.
	hkrlf_fifo #(
		.DATA_W (Q_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (push),
		.wr_data   ({push_item, push_slot}),
		.not_full  (q_not_full),
		.not_empty (q_not_empty),
		.rd_en     (q_pop),
		.rd_data   (q_rd_data)
	);

	assign q_item = q_rd_data[Q_W-1 -: ITEM_W];
	assign q_slot = q_rd_data[IDX_W-1:0];

	// Back part: table lookup, decision, update and the result register that
	// lets the next item be taken and looked up while a result waits on out_ready.
	hkrlf_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.IDX_W         (IDX_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_not_empty),
		.q_ready      (q_pop),
		.q_item       (q_item),
		.q_slot       (q_slot),
		.min_interval (min_interval_q),
		.clearing     (clearing),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.should_log   (should_log)
	);

endmodule
